// ----- rtl/core/hqmb_pkg.sv -----
// ----------------------------------------------------------------------------
// hqmb_pkg
// Shared widths, register codes and scale tables for the quantiser
// multiplier and bias calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package hqmb_pkg;

  // field widths
  localparam int QP_W      = 6;
  localparam int POS_W     = 6;
  localparam int LV_W      = 8;
  localparam int MF_W      = 19;
  localparam int MF_FULL_W = 20;
  localparam int BIAS_W    = 16;
  localparam int FRAC_W    = 6;
  localparam int RB_W      = 10;
  localparam int RB_PREC   = 5;
  localparam int SCALE_W   = 15;
  localparam int RECIP_W   = 41;
  localparam int QDIV_W    = 4;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  // register codes (word index on the bus)
  localparam logic [1:0] REG_MF_FRAC   = 2'd0;
  localparam logic [1:0] REG_BIAS_FRAC = 2'd1;
  localparam logic [1:0] REG_RND_BIAS  = 2'd2;

  // reset values and usable ranges
  localparam logic [FRAC_W-1:0] MF_FRAC_RST   = 6'd28;
  localparam logic [FRAC_W-1:0] BIAS_FRAC_RST = 6'd25;
  localparam logic [FRAC_W-1:0] MF_FRAC_MIN   = 6'd22;
  localparam logic [FRAC_W-1:0] BIAS_FRAC_MIN = 6'd25;
  localparam logic [FRAC_W-1:0] FRAC_MAX      = 6'd40;

  // base scale for 4x4, row = qp mod 6, three classes per row
  localparam logic [SCALE_W-1:0] SCALE4_ROM [0:17] = '{
    15'd13107, 15'd8066, 15'd5243,
    15'd11916, 15'd7490, 15'd4660,
    15'd10082, 15'd6554, 15'd4194,
    15'd9362,  15'd5825, 15'd3647,
    15'd8192,  15'd5243, 15'd3355,
    15'd7282,  15'd4559, 15'd2893
  };

  // base scale for 8x8, six classes per row
  localparam logic [SCALE_W-1:0] SCALE8_ROM [0:35] = '{
    15'd13107, 15'd11428, 15'd20972, 15'd12222, 15'd16777, 15'd15481,
    15'd11916, 15'd10826, 15'd19174, 15'd11058, 15'd14980, 15'd14290,
    15'd10082, 15'd8943,  15'd15978, 15'd9675,  15'd12710, 15'd11985,
    15'd9362,  15'd8228,  15'd14913, 15'd8931,  15'd11984, 15'd11259,
    15'd8192,  15'd7346,  15'd13159, 15'd7740,  15'd10486, 15'd9777,
    15'd7282,  15'd6428,  15'd11570, 15'd6830,  15'd9118,  15'd8640
  };

  // 8x8 position class, indexed by folded position
  localparam logic [2:0] CLASS8_ROM [0:15] = '{
    3'd0, 3'd3, 3'd4, 3'd3, 3'd3, 3'd1, 3'd5, 3'd1,
    3'd4, 3'd5, 3'd2, 3'd5, 3'd3, 3'd1, 3'd5, 3'd1
  };

endpackage

`default_nettype wire

// ----- rtl/core/hqmb_rdiv.sv -----
// ----------------------------------------------------------------------------
// hqmb_rdiv
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// word carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module hqmb_rdiv #(
  parameter int NUM_W  = 41,
  parameter int DEN_W  = 8,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  input  wire logic [SIDE_W-1:0] side,
  output logic                   out_valid,
  output logic [NUM_W-1:0]       quo,
  output logic [SIDE_W-1:0]      side_out
);

  // stage registers; numerator shifts out as quotient bits shift in
  logic [NUM_W:1]    vld;
  logic [NUM_W-1:0]  nm [1:NUM_W];
  logic [DEN_W-1:0]  rm [1:NUM_W];
  logic [DEN_W-1:0]  dn [1:NUM_W];
  logic [SIDE_W-1:0] sd [1:NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic              cv;
    logic [NUM_W-1:0]  cn;
    logic [DEN_W-1:0]  cr;
    logic [DEN_W-1:0]  cd;
    logic [SIDE_W-1:0] cs;
    logic [DEN_W:0]    t;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (i == 0) begin : g_src_in
      assign cv = in_valid;
      assign cn = num;
      assign cr = '0;
      assign cd = den;
      assign cs = side;
    end else begin : g_src_reg
      assign cv = vld[i];
      assign cn = nm[i];
      assign cr = rm[i];
      assign cd = dn[i];
      assign cs = sd[i];
    end

    // one trial subtraction
    assign t    = {cr, cn[NUM_W-1]};
    assign diff = t - {1'b0, cd};
    assign ge   = (t >= {1'b0, cd});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nm[i+1] <= {cn[NUM_W-2:0], ge};
        rm[i+1] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        dn[i+1] <= cd;
        sd[i+1] <= cs;
      end
    end
  end

  assign out_valid = vld[NUM_W];
  assign quo       = nm[NUM_W];
  assign side_out  = sd[NUM_W];

endmodule

`default_nettype wire

// ----- rtl/core/h264_quant_mf_bias_calc.sv -----
// Throughput: one word per cycle while no result word is stalled; the two
// 41-stage bit-serial dividers and the split multipliers are fully pipelined.
// The whole pipeline holds while a result word is stalled.
// Reset (synchronous) clears all valid bits and restores the registers to
// mf_frac_bits 28, bias_frac_bits 25, rounding_bias 0.
// ----------------------------------------------------------------------------
// h264_quant_mf_bias_calc
// Quantiser multiplier and dead-zone bias from scaling-list entries.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_quant_mf_bias_calc (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [hqmb_pkg::ADDR_W-1:0] paddr,
  input  wire logic [hqmb_pkg::DATA_W-1:0] pwdata,
  output logic      [hqmb_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [hqmb_pkg::QP_W-1:0]   qp,
  input  wire logic                        is_8x8,
  input  wire logic [hqmb_pkg::POS_W-1:0]  position,
  input  wire logic [hqmb_pkg::LV_W-1:0]   list_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [hqmb_pkg::MF_W-1:0]   mult_factor,
  output logic      [hqmb_pkg::BIAS_W-1:0] deadzone_bias
);
  import hqmb_pkg::*;

  localparam int SIDE1_W = MF_W + QDIV_W + 1;

  // configuration registers
  logic [FRAC_W-1:0] mf_frac_bits;
  logic [FRAC_W-1:0] bias_frac_bits;
  logic [RB_W-1:0]   rounding_bias;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      mf_frac_bits   <= MF_FRAC_RST;
      bias_frac_bits <= BIAS_FRAC_RST;
      rounding_bias  <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MF_FRAC:   mf_frac_bits   <= pwdata[FRAC_W-1:0];
        REG_BIAS_FRAC: bias_frac_bits <= pwdata[FRAC_W-1:0];
        REG_RND_BIAS:  rounding_bias  <= pwdata[RB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MF_FRAC:   prdata = {{(DATA_W-FRAC_W){1'b0}}, mf_frac_bits};
      REG_BIAS_FRAC: prdata = {{(DATA_W-FRAC_W){1'b0}}, bias_frac_bits};
      REG_RND_BIAS:  prdata = {{(DATA_W-RB_W){1'b0}}, rounding_bias};
      default:       prdata = '0;
    endcase
  end

  // clamped fraction widths
  logic [FRAC_W-1:0] fm_use;
  logic [FRAC_W-1:0] fb_use;

  always_comb begin
    if (mf_frac_bits < MF_FRAC_MIN)   fm_use = MF_FRAC_MIN;
    else if (mf_frac_bits > FRAC_MAX) fm_use = FRAC_MAX;
    else                              fm_use = mf_frac_bits;
    if (bias_frac_bits < BIAS_FRAC_MIN) fb_use = BIAS_FRAC_MIN;
    else if (bias_frac_bits > FRAC_MAX) fb_use = FRAC_MAX;
    else                                fb_use = bias_frac_bits;
  end

  // pipeline advance: everything moves unless the result word is held
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // input decode: qp split, position class, base scale, first dividend
  logic [11:0]        qp_prod;
  logic [QDIV_W-1:0]  qdiv_w;
  logic [5:0]         six_q;
  logic [2:0]         row;
  logic [1:0]         k4;
  logic [4:0]         idx4;
  logic [2:0]         k8;
  logic [5:0]         idx8;
  logic [SCALE_W-1:0] scale_w;
  logic [LV_W-1:0]    d1_w;

  always_comb begin
    qp_prod = 12'(qp) * 12'd43;
    qdiv_w  = qp_prod[11:8];
    six_q   = {qdiv_w, 2'b00} + {1'b0, qdiv_w, 1'b0};
    row     = 3'(qp - six_q);
    k4      = {1'b0, position[0]} + {1'b0, position[2]};
    idx4    = 5'({2'b00, row} * 5'd3 + {3'b000, k4});
    k8      = CLASS8_ROM[{position[4:3], position[1:0]}];
    idx8    = 6'({3'b000, row} * 6'd6 + {3'b000, k8});
    scale_w = is_8x8 ? SCALE8_ROM[idx8] : SCALE4_ROM[idx4];
    d1_w    = (list_value == '0) ? LV_W'(1) : list_value;
  end

  // stage 1 register
  logic                v1;
  logic [RECIP_W-1:0]  num1;
  logic [LV_W-1:0]     den1;
  logic [SIDE1_W-1:0]  side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1  <= (RECIP_W'(1) << fm_use) + RECIP_W'(d1_w[LV_W-1:1]);
      den1  <= d1_w;
      side1 <= {scale_w, 4'b0000, qdiv_w, !is_8x8};
    end
  end

  // reciprocal of the list value
  logic               vd1;
  logic [RECIP_W-1:0] q1;
  logic [SIDE1_W-1:0] sd1;

  hqmb_rdiv #(
    .NUM_W  (RECIP_W),
    .DEN_W  (LV_W),
    .SIDE_W (SIDE1_W)
  ) u_div_mf (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .num       (num1),
    .den       (den1),
    .side      (side1),
    .out_valid (vd1),
    .quo       (q1),
    .side_out  (sd1)
  );

  // stage 2: split product of scale*16 and reciprocal
  logic               v2;
  logic [39:0]        plo;
  logic [38:0]        phi;
  logic [QDIV_W-1:0]  qdiv2;
  logic               small2;
  logic [MF_W-1:0]    scl16;

  assign scl16 = sd1[SIDE1_W-1:QDIV_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= vd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plo    <= 40'(scl16) * 40'(q1[20:0]);
      phi    <= 39'(scl16) * 39'(q1[40:21]);
      qdiv2  <= sd1[QDIV_W:1];
      small2 <= sd1[0];
    end
  end

  // stage 3: sum partial products with rounding
  logic              v3;
  logic [60:0]       sum1;
  logic [QDIV_W-1:0] qdiv3;
  logic              small3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum1   <= 61'(plo) + 61'({phi, 21'd0}) + (61'd1 << (fm_use - 6'd1));
      qdiv3  <= qdiv2;
      small3 <= small2;
    end
  end

  // stage 4: drop the fraction
  logic                 v4;
  logic [MF_FULL_W-1:0] mf0;
  logic [QDIV_W-1:0]    qdiv4;
  logic                 small4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mf0    <= MF_FULL_W'(sum1 >> fm_use);
      qdiv4  <= qdiv3;
      small4 <= small3;
    end
  end

  // qp shift, left by one for 4x4 with qp below six
  logic [QDIV_W-1:0]    sh;
  logic [MF_FULL_W:0]   half;
  logic [MF_FULL_W-1:0] mf1;
  logic [MF_FULL_W-1:0] d2_w;

  always_comb begin
    sh   = qdiv4 - QDIV_W'(small4);
    half = (sh == '0) ? '0 : ((MF_FULL_W+1)'(1) << (sh - QDIV_W'(1)));
    if (small4 && (qdiv4 == '0)) begin
      mf1 = {mf0[MF_FULL_W-2:0], 1'b0};
    end else begin
      mf1 = MF_FULL_W'(((MF_FULL_W+1)'(mf0) + half) >> sh);
    end
    d2_w = (mf1 == '0) ? MF_FULL_W'(1) : mf1;
  end

  // stage 5: second dividend
  logic                 v5;
  logic [RECIP_W-1:0]   num2;
  logic [MF_FULL_W-1:0] den2;
  logic [MF_W-1:0]      mf5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num2 <= (RECIP_W'(1) << fb_use) + RECIP_W'(d2_w[MF_FULL_W-1:1]);
      den2 <= d2_w;
      mf5  <= mf1[MF_W-1:0];
    end
  end

  // reciprocal of the multiplier
  logic               vd2;
  logic [RECIP_W-1:0] q2;
  logic [MF_W-1:0]    mfd2;

  hqmb_rdiv #(
    .NUM_W  (RECIP_W),
    .DEN_W  (MF_FULL_W),
    .SIDE_W (MF_W)
  ) u_div_bias (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .num       (num2),
    .den       (den2),
    .side      (mf5),
    .out_valid (vd2),
    .quo       (q2),
    .side_out  (mfd2)
  );

  // stage 6: split product of bias*32 and reciprocal
  logic                     v6;
  logic [35:0]              blo;
  logic [34:0]              bhi;
  logic [MF_W-1:0]          mf6;
  logic [RB_W+RB_PREC-1:0]  rb32;

  assign rb32 = {rounding_bias, {RB_PREC{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= vd2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blo <= 36'(rb32) * 36'(q2[20:0]);
      bhi <= 35'(rb32) * 35'(q2[40:21]);
      mf6 <= mfd2;
    end
  end

  // stage 7: sum with rounding
  logic            v7;
  logic [56:0]     bsum;
  logic [MF_W-1:0] mf7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bsum <= 57'(blo) + 57'({bhi, 21'd0}) + (57'd1 << (fb_use - 6'd1));
      mf7  <= mf6;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deadzone_bias <= BIAS_W'(bsum >> fb_use);
      mult_factor   <= mf7;
    end
  end

  // checks
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result word");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted word missing from first stage");

  a_div_to_mult: assert property (@(posedge clk) disable iff (rst)
    (vd1 && en) |=> v2)
    else $error("divider word lost before multiplier");

  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    (v7 && en) |=> out_valid)
    else $error("word lost before output register");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quantiser multiplier and dead-zone bias block.
// A directed table of words comes first, then random words under several
// register settings and idling patterns. Every result word is checked
// against its typed value or an in-bench multiplier and bias calculation.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hqmb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic [MF_W-1:0]   mf;
    logic [BIAS_W-1:0] bias;
  } quant_result_t;

  typedef struct {
    logic [QP_W-1:0]   qp;
    logic              big;
    logic [POS_W-1:0]  pos;
    logic [LV_W-1:0]   lv;
    bit                typed;
    logic [MF_W-1:0]   mf;
    logic [BIAS_W-1:0] bias;
  } directed_row_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic [QP_W-1:0] qp = '0;
  logic is_8x8 = 0;
  logic [POS_W-1:0] position = '0;
  logic [LV_W-1:0] list_value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [MF_W-1:0] mult_factor;
  logic [BIAS_W-1:0] deadzone_bias;

  // shadow register copy
  logic [FRAC_W-1:0] mf_frac_sh = MF_FRAC_RST;
  logic [FRAC_W-1:0] bias_frac_sh = BIAS_FRAC_RST;
  logic [RB_W-1:0]   rnd_bias_sh = '0;

  quant_result_t pending_results[$];
  int fail_count = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;

  h264_quant_mf_bias_calc uut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // multiplier and bias for one coefficient under current registers
  function automatic quant_result_t calc_quant(logic [QP_W-1:0] q, logic big,
                                               logic [POS_W-1:0] p, logic [LV_W-1:0] lv);
    bit [63:0] fm, fb, scale, recip, mf, bf, bias, div, row;
    int shift, k;
    quant_result_t r;
    fm = (mf_frac_sh < MF_FRAC_MIN) ? MF_FRAC_MIN : (mf_frac_sh > FRAC_MAX) ? FRAC_MAX : mf_frac_sh;
    fb = (bias_frac_sh < BIAS_FRAC_MIN) ? BIAS_FRAC_MIN :
         (bias_frac_sh > FRAC_MAX) ? FRAC_MAX : bias_frac_sh;
    row = q % 6;
    if (big) begin
      k = CLASS8_ROM[{p[4:3], p[1:0]}];
      scale = SCALE8_ROM[row * 6 + k];
      shift = q / 6;
    end else begin
      k = p[0] + p[2];
      scale = SCALE4_ROM[row * 3 + k];
      shift = q / 6 - 1;
    end
    div = (lv == 0) ? 1 : lv;
    recip = ((64'd1 << fm) + (div >> 1)) / div;
    mf = (scale * 16 * recip + (64'd1 << (fm - 1))) >> fm;
    if (shift < 0) mf = mf << 1;
    else if (shift > 0) mf = (mf + (64'd1 << (shift - 1))) >> shift;
    div = (mf == 0) ? 1 : mf;
    bf = ((64'd1 << fb) + (div >> 1)) / div;
    bias = ((64'(rnd_bias_sh) << RB_PREC) * bf + (64'd1 << (fb - 1))) >> fb;
    r.mf = mf[MF_W-1:0];
    r.bias = bias[BIAS_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    fail_count++;
  endtask

  // result side: check accepted words, drive stall
  always @(posedge clk) begin
    quant_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (mult_factor !== want.mf) report_mismatch("mult_factor", mult_factor, want.mf);
        if (deadzone_bias !== want.bias)
          report_mismatch("deadzone_bias", deadzone_bias, want.bias);
      end
    end
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // offer one word and wait until it is taken
  task automatic send_word(logic [QP_W-1:0] q, logic big, logic [POS_W-1:0] p,
                           logic [LV_W-1:0] lv, bit typed = 0,
                           quant_result_t typed_res = '{default: 0});
    // idle cycle by cycle so the idle share matches the percentage
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    qp <= q;
    is_8x8 <= big;
    position <= p;
    list_value <= lv;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(typed ? typed_res : calc_quant(q, big, p, lv));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_MF_FRAC:   mf_frac_sh = val[FRAC_W-1:0];
      REG_BIAS_FRAC: bias_frac_sh = val[FRAC_W-1:0];
      default:       rnd_bias_sh = val[RB_W-1:0];
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_word();
    logic [QP_W-1:0] q;
    logic [LV_W-1:0] lv;
    q = ($urandom_range(9) == 0) ? QP_W'($urandom_range(0, 63)) : QP_W'($urandom_range(1, 51));
    lv = ($urandom_range(49) == 0) ? 8'd0 : LV_W'($urandom_range(1, 255));
    send_word(q, 1'($urandom), POS_W'($urandom_range(0, 63)), lv);
  endtask

  directed_row_t directed_rows[] = '{
    '{6'd6,  1'b0, 6'd0,  8'd16,  1, 19'd13107,  16'd0},
    '{6'd12, 1'b1, 6'd0,  8'd16,  1, 19'd3277,   16'd0},
    '{6'd6,  1'b0, 6'd0,  8'd0,   1, 19'd209712, 16'd0},
    '{6'd6,  1'b1, 6'd0,  8'd1,   1, 19'd104856, 16'd0},
    '{6'd0,  1'b0, 6'd5,  8'd1,   0, 0, 0},
    '{6'd1,  1'b0, 6'd63, 8'd255, 0, 0, 0},
    '{6'd5,  1'b0, 6'd16, 8'd128, 0, 0, 0},
    '{6'd51, 1'b0, 6'd15, 8'd1,   0, 0, 0},
    '{6'd52, 1'b0, 6'd4,  8'd200, 0, 0, 0},
    '{6'd63, 1'b1, 6'd63, 8'd255, 0, 0, 0},
    '{6'd0,  1'b1, 6'd1,  8'd1,   0, 0, 0},
    '{6'd1,  1'b1, 6'd2,  8'd3,   0, 0, 0},
    '{6'd2,  1'b1, 6'd10, 8'd7,   0, 0, 0},
    '{6'd3,  1'b1, 6'd5,  8'd42,  0, 0, 0},
    '{6'd4,  1'b1, 6'd6,  8'd99,  0, 0, 0},
    '{6'd51, 1'b1, 6'd42, 8'd255, 0, 0, 0},
    '{6'd27, 1'b0, 6'd10, 8'd0,   0, 0, 0}
  };

  // register settings per random phase: mf frac, bias frac, rounding bias
  int phase_cfg[6][3] = '{
    '{22, 25, 1023}, '{40, 40, 1023}, '{0, 0, 500},
    '{63, 63, 1}, '{31, 33, 0}, '{28, 25, 700}
  };

  initial begin
    quant_result_t typed_res;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed words under reset register values
    send_idle_pct = 20;
    recv_idle_pct = 20;
    foreach (directed_rows[i]) begin
      typed_res.mf = directed_rows[i].mf;
      typed_res.bias = directed_rows[i].bias;
      send_word(directed_rows[i].qp, directed_rows[i].big, directed_rows[i].pos,
                directed_rows[i].lv, directed_rows[i].typed, typed_res);
    end
    wait_drained();

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_MF_FRAC, phase_cfg[ph][0]);
      write_reg(REG_BIAS_FRAC, phase_cfg[ph][1]);
      write_reg(REG_RND_BIAS, (ph == 4) ? $urandom_range(0, 1023) : phase_cfg[ph][2]);
      send_idle_pct = (ph < 2) ? 9 : (ph < 4) ? 82 : 0;
      recv_idle_pct = (ph < 2) ? 82 : (ph < 4) ? 9 : 0;
      if (ph == 4) hold_req = 1;
      for (int n = 0; n < 305; n++) begin
        if (ph == 5 && n == 150) begin
          wait_drained();
          @(posedge clk);
        end
        send_random_word();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
